// File: design/mpvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpvc_pkg;

    localparam int MAX_OBS      = 16;
    localparam int MAX_VERT     = 32;
    localparam int COORD_W      = 16;
    localparam int SAMPLE_STEPS = 20;
    localparam int NUM_POLYS    = MAX_OBS + 1;
    localparam int POLY_W       = $clog2(NUM_POLYS);
    localparam int VIDX_W       = $clog2(MAX_VERT);
    localparam int CNT_W        = VIDX_W + 1;
    localparam int ADDR_W       = POLY_W + VIDX_W;
    localparam int STEP_W       = $clog2(SAMPLE_STEPS + 1);
    localparam int NUM_W        = COORD_W + 7;
    localparam int MAG_W        = NUM_W - 1;
    localparam int RECIP_SH     = MAG_W + $clog2(SAMPLE_STEPS);
    localparam int RECIP_W      = MAG_W + 1;
    localparam longint RECIP    = ((longint'(1) << RECIP_SH) + SAMPLE_STEPS - 1) / SAMPLE_STEPS;
    localparam int QPROD_W      = MAG_W + RECIP_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_POINT   = 2'd1;
    localparam logic [1:0] KIND_SEGMENT = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_POINT,
        OP_SEGMENT
    } t_op;

    typedef struct packed {
        logic [1:0]                kind;
        logic [4:0]                polygon_id;
        logic [4:0]                vertex_index;
        logic                      last_vertex;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_in;

    typedef struct packed {
        logic inside_border;
        logic in_obstacle;
        logic point_valid;
        logic segment_blocked;
    } t_out;

    typedef struct packed {
        t_op                       op;
        logic [POLY_W-1:0]         polygon_id;
        logic [VIDX_W-1:0]         vertex_index;
        logic                      last_vertex;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_cmd;

endpackage
`default_nettype wire

// File: design/map_point_validity_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake        Payload
// command   in         push / full      i_in  (t_in)
// result    out        empty / pop      o_out (t_out)
// config    in         i_cfg_we         i_cfg_wdata (obstacle count)
//
// A load is written to vertex memory by the execution unit. Each polygon is walked
// edge by edge with one vertex memory read per edge plus one for the closing vertex,
// and an empty polygon is skipped without reads; a segment query does the divide
// by 20 once per sample and runs up to 21 samples over the obstacles.
// Reset clears vertex counts and the obstacle count; vertex memory is not cleared.
// A 4-deep command queue and a 2-deep result queue let each side stall alone.
module map_point_validity_checker_core import mpvc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    input  wire t_in        i_in,
    output logic            full,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_wdata,
    output logic            empty,
    input  wire logic       pop,
    output t_out            o_out
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_take;
    logic w_res_push;
    t_out w_res;
    logic w_res_full;

    mpvc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in        (i_in),
        .full        (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    mpvc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    mpvc_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// File: design/mpvc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mpvc_front import mpvc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    input  wire t_in  i_in,
    output logic      full,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_take
);

    t_cmd       r_q [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_fill;
    logic       w_keep;
    logic       w_wr;
    t_cmd       w_cmd;

    always_comb begin
        w_keep             = 1'b1;
        w_cmd.op           = OP_LOAD;
        w_cmd.polygon_id   = i_in.polygon_id;
        w_cmd.vertex_index = i_in.vertex_index;
        w_cmd.last_vertex  = i_in.last_vertex;
        w_cmd.coord_x      = i_in.coord_x;
        w_cmd.coord_y      = i_in.coord_y;
        w_cmd.end_x        = i_in.end_x;
        w_cmd.end_y        = i_in.end_y;
        unique case (i_in.kind)
            KIND_LOAD: begin
                w_cmd.op = OP_LOAD;
                w_keep   = (i_in.polygon_id <= 5'(MAX_OBS));
            end
            KIND_POINT:   w_cmd.op = OP_POINT;
            KIND_SEGMENT: w_cmd.op = OP_SEGMENT;
            default:      w_keep   = 1'b0;
        endcase
    end

    assign full        = (r_fill == 3'd4);
    assign o_cmd_valid = (r_fill != 3'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = push && !full && w_keep;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_cmd_take) begin
                r_rp <= r_rp + 2'd1;
            end
            r_fill <= r_fill + {2'b0, w_wr} - {2'b0, i_cmd_take};
        end
    end

endmodule
`default_nettype wire

// File: design/mpvc_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module mpvc_engine import mpvc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_take,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_wdata,
    output logic            o_res_push,
    output t_out            o_res,
    input  wire logic       i_res_full
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SAMP = 9'b000000010,
        S_DIV  = 9'b000000100,
        S_POLY = 9'b000001000,
        S_PRV  = 9'b000010000,
        S_DAT  = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_CMP  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [2*COORD_W-1:0]      r_mem [NUM_POLYS*MAX_VERT];
    logic [2*COORD_W-1:0]      r_rdata;
    logic [CNT_W-1:0]          r_count [NUM_POLYS];
    logic [POLY_W-1:0]         r_obs;

    logic                      r_is_point;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [NUM_W-1:0]   r_nx;
    logic signed [NUM_W-1:0]   r_ny;
    logic signed [NUM_W-1:0]   r_sdx;
    logic signed [NUM_W-1:0]   r_sdy;
    logic [STEP_W-1:0]         r_si;
    logic                      r_negx;
    logic                      r_negy;
    logic [MAG_W-1:0]          r_mx;
    logic [MAG_W-1:0]          r_my;
    logic [QPROD_W-1:0]        r_qx;
    logic [QPROD_W-1:0]        r_qy;
    logic                      r_dstep;
    logic [POLY_W-1:0]         r_poly;
    logic [VIDX_W-1:0]         r_vi;
    logic [2*COORD_W-1:0]      r_prev;
    logic                      r_cross;
    logic signed [DIFF_W-1:0]  r_a;
    logic signed [DIFF_W-1:0]  r_dy;
    logic signed [DIFF_W-1:0]  r_b;
    logic signed [DIFF_W-1:0]  r_c;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [PROD_W-1:0]  r_p2;
    logic                      r_in;
    logic                      r_ib;
    logic                      r_io;
    logic                      r_blk;

    logic                      w_we;
    logic                      w_rd;
    logic [ADDR_W-1:0]         w_raddr;
    logic [CNT_W-1:0]          w_n;
    logic [CNT_W-1:0]          w_nm1;
    logic                      w_last_v;
    logic                      w_last_poly;
    logic                      w_tog;
    logic                      w_pd;
    logic                      w_pd_in;
    logic signed [COORD_W-1:0] w_xi;
    logic signed [COORD_W-1:0] w_yi;
    logic signed [COORD_W-1:0] w_xj;
    logic signed [COORD_W-1:0] w_yj;
    logic signed [NUM_W-1:0]   w_sx;
    logic signed [NUM_W-1:0]   w_sy;
    logic [NUM_W-1:0]          w_absx;
    logic [NUM_W-1:0]          w_absy;
    logic [COORD_W-1:0]        w_qx;
    logic [COORD_W-1:0]        w_qy;

    assign w_n         = r_count[r_poly];
    assign w_nm1       = w_n - CNT_W'(1);
    assign w_last_v    = (r_vi == w_nm1[VIDX_W-1:0]);
    assign w_last_poly = (r_poly == r_obs);
    assign w_tog       = r_cross && (r_dy[DIFF_W-1] ? (r_p1 > r_p2) : (r_p1 < r_p2));
    assign w_xi        = r_rdata[2*COORD_W-1:COORD_W];
    assign w_yi        = r_rdata[COORD_W-1:0];
    assign w_xj        = r_prev[2*COORD_W-1:COORD_W];
    assign w_yj        = r_prev[COORD_W-1:0];

    assign w_sx   = {{(NUM_W-COORD_W){i_cmd.coord_x[COORD_W-1]}}, i_cmd.coord_x};
    assign w_sy   = {{(NUM_W-COORD_W){i_cmd.coord_y[COORD_W-1]}}, i_cmd.coord_y};
    assign w_absx = r_nx[NUM_W-1] ? NUM_W'(-r_nx) : NUM_W'(r_nx);
    assign w_absy = r_ny[NUM_W-1] ? NUM_W'(-r_ny) : NUM_W'(r_ny);
    assign w_qx   = r_qx[RECIP_SH +: COORD_W];
    assign w_qy   = r_qy[RECIP_SH +: COORD_W];

    always_comb begin
        n_state    = r_state;
        o_cmd_take = 1'b0;
        w_we       = 1'b0;
        w_rd       = 1'b0;
        w_raddr    = '0;
        o_res_push = 1'b0;
        w_pd       = 1'b0;
        w_pd_in    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.op)
                        OP_LOAD:    w_we = 1'b1;
                        OP_POINT:   n_state = S_POLY;
                        OP_SEGMENT: n_state = (r_obs == '0) ? S_OUT : S_SAMP;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SAMP: n_state = S_DIV;
            S_DIV: begin
                if (r_dstep) begin
                    n_state = S_POLY;
                end
            end
            S_POLY: begin
                if (w_n == '0) begin
                    w_pd = 1'b1;
                end else begin
                    w_rd    = 1'b1;
                    w_raddr = {r_poly, w_nm1[VIDX_W-1:0]};
                    n_state = S_PRV;
                end
            end
            S_PRV: begin
                w_rd    = 1'b1;
                w_raddr = {r_poly, {VIDX_W{1'b0}}};
                n_state = S_DAT;
            end
            S_DAT: n_state = S_MUL;
            S_MUL: n_state = S_CMP;
            S_CMP: begin
                if (w_last_v) begin
                    w_pd    = 1'b1;
                    w_pd_in = r_in ^ w_tog;
                end else begin
                    w_rd    = 1'b1;
                    w_raddr = {r_poly, r_vi + VIDX_W'(1)};
                    n_state = S_DAT;
                end
            end
            S_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (w_pd) begin
            priority if (r_is_point && r_poly == '0) begin
                n_state = (r_obs == '0) ? S_OUT : S_POLY;
            end else if (r_is_point) begin
                n_state = (w_pd_in || w_last_poly) ? S_OUT : S_POLY;
            end else if (w_pd_in) begin
                n_state = S_OUT;
            end else if (w_last_poly) begin
                n_state = (r_si == STEP_W'(SAMPLE_STEPS)) ? S_OUT : S_SAMP;
            end else begin
                n_state = S_POLY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[{i_cmd.polygon_id, i_cmd.vertex_index}] <= {i_cmd.coord_x, i_cmd.coord_y};
        end
        if (w_rd) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_obs   <= '0;
            for (int k = 0; k < NUM_POLYS; k++) begin
                r_count[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_obs <= (i_cfg_wdata > 5'(MAX_OBS)) ? POLY_W'(MAX_OBS)
                                                     : POLY_W'(i_cfg_wdata);
            end
            if (w_we && i_cmd.last_vertex) begin
                r_count[i_cmd.polygon_id] <= {1'b0, i_cmd.vertex_index} + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.op != OP_LOAD) begin
                    r_is_point <= (i_cmd.op == OP_POINT);
                    r_px       <= i_cmd.coord_x;
                    r_py       <= i_cmd.coord_y;
                    r_nx       <= (w_sx <<< 4) + (w_sx <<< 2);
                    r_ny       <= (w_sy <<< 4) + (w_sy <<< 2);
                    r_sdx      <= NUM_W'(i_cmd.end_x) - w_sx;
                    r_sdy      <= NUM_W'(i_cmd.end_y) - w_sy;
                    r_si       <= '0;
                    r_ib       <= 1'b0;
                    r_io       <= 1'b0;
                    r_blk      <= 1'b0;
                    r_poly     <= (i_cmd.op == OP_POINT) ? POLY_W'(0) : POLY_W'(1);
                end
            end
            S_SAMP: begin
                r_negx  <= r_nx[NUM_W-1];
                r_negy  <= r_ny[NUM_W-1];
                r_mx    <= w_absx[MAG_W-1:0];
                r_my    <= w_absy[MAG_W-1:0];
                r_dstep <= 1'b0;
                r_poly  <= POLY_W'(1);
            end
            S_DIV: begin
                r_dstep <= 1'b1;
                if (!r_dstep) begin
                    r_qx <= r_mx * RECIP_W'(RECIP);
                    r_qy <= r_my * RECIP_W'(RECIP);
                end else begin
                    r_px <= r_negx ? COORD_W'(-w_qx) : w_qx;
                    r_py <= r_negy ? COORD_W'(-w_qy) : w_qy;
                end
            end
            S_POLY: r_in <= 1'b0;
            S_PRV: begin
                r_prev <= r_rdata;
                r_vi   <= '0;
            end
            S_DAT: begin
                r_prev  <= r_rdata;
                r_cross <= (w_yi > r_py) != (w_yj > r_py);
                r_a     <= {r_px[COORD_W-1], r_px} - {w_xi[COORD_W-1], w_xi};
                r_dy    <= {w_yj[COORD_W-1], w_yj} - {w_yi[COORD_W-1], w_yi};
                r_b     <= {w_xj[COORD_W-1], w_xj} - {w_xi[COORD_W-1], w_xi};
                r_c     <= {r_py[COORD_W-1], r_py} - {w_yi[COORD_W-1], w_yi};
            end
            S_MUL: begin
                r_p1 <= r_a * r_dy;
                r_p2 <= r_b * r_c;
            end
            S_CMP: begin
                r_in <= r_in ^ w_tog;
                if (!w_last_v) begin
                    r_vi <= r_vi + VIDX_W'(1);
                end
            end
            S_OUT: ;
            default: ;
        endcase
        if (w_pd) begin
            priority if (r_is_point && r_poly == '0) begin
                r_ib <= w_pd_in;
            end else if (r_is_point) begin
                r_io <= r_io | w_pd_in;
            end else begin
                r_blk <= r_blk | w_pd_in;
            end
            if (!r_is_point && w_last_poly) begin
                r_poly <= POLY_W'(1);
                r_si   <= r_si + STEP_W'(1);
                r_nx   <= r_nx + r_sdx;
                r_ny   <= r_ny + r_sdy;
            end else begin
                r_poly <= r_poly + POLY_W'(1);
            end
        end
    end

    always_comb begin
        o_res.inside_border   = r_is_point & r_ib;
        o_res.in_obstacle     = r_is_point & r_io;
        o_res.point_valid     = r_is_point & r_ib & ~r_io;
        o_res.segment_blocked = ~r_is_point & r_blk;
    end

endmodule
`default_nettype wire

// File: design/mpvc_resq.sv
`timescale 1ns / 1ps
`default_nettype none
module mpvc_resq import mpvc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_out i_res,
    output logic      o_full,
    output logic      empty,
    input  wire logic pop,
    output t_out      o_out
);

    t_out       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    logic       w_wr;
    logic       w_rd;

    assign o_full = (r_fill == 2'd2);
    assign empty  = (r_fill == 2'd0);
    assign o_out  = r_q[r_rp];
    assign w_wr   = i_push && !o_full;
    assign w_rd   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import mpvc_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    t_in        i_in;
    logic       full;
    logic       i_cfg_we;
    logic [4:0] i_cfg_wdata;
    logic       empty;
    logic       pop;
    t_out       o_out;

    map_point_validity_checker_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in       (i_in),
        .full       (full),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out)
    );

    localparam int CYCLE_LIMIT = 150_000_000;

    logic signed [COORD_W-1:0] vert_x[NUM_POLYS][MAX_VERT];
    logic signed [COORD_W-1:0] vert_y[NUM_POLYS][MAX_VERT];
    int unsigned               poly_len[NUM_POLYS];
    int unsigned               obs_active;

    t_out        expected_q[$];
    int unsigned error_count;
    longint      cycle_count;
    int unsigned burst_left;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit crosses_edge(input longint px, input longint py,
                                        input longint xi, input longint yi,
                                        input longint xj, input longint yj);
        longint dy;
        longint lhs;
        longint rhs;
        if ((yi > py) == (yj > py)) return 1'b0;
        dy  = yj - yi;
        lhs = (px - xi) * dy;
        rhs = (xj - xi) * (py - yi);
        return dy > 0 ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic bit point_in_poly(input int p, input longint px, input longint py);
        bit          hit;
        int unsigned n;
        int          j;
        hit = 1'b0;
        n = poly_len[p];
        for (int i = 0; i < n; i++) begin
            j = (i == 0) ? n - 1 : i - 1;
            if (crosses_edge(px, py, vert_x[p][i], vert_y[p][i], vert_x[p][j], vert_y[p][j]))
                hit = ~hit;
        end
        return hit;
    endfunction

    function automatic bit hits_obstacle(input longint px, input longint py);
        int unsigned cnt;
        cnt = obs_active > MAX_OBS ? MAX_OBS : obs_active;
        for (int k = 1; k <= cnt; k++)
            if (point_in_poly(k, px, py)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit segment_hits(input longint x1, input longint y1,
                                        input longint x2, input longint y2);
        longint sx;
        longint sy;
        for (int i = 0; i <= SAMPLE_STEPS; i++) begin
            sx = (x1 * SAMPLE_STEPS + i * (x2 - x1)) / SAMPLE_STEPS;
            sy = (y1 * SAMPLE_STEPS + i * (y2 - y1)) / SAMPLE_STEPS;
            if (hits_obstacle(sx, sy)) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_validity(input t_in w);
        t_out r;
        r = '0;
        case (w.kind)
            KIND_LOAD: begin
                if (w.polygon_id < NUM_POLYS) begin
                    vert_x[w.polygon_id][w.vertex_index] = w.coord_x;
                    vert_y[w.polygon_id][w.vertex_index] = w.coord_y;
                    if (w.last_vertex) poly_len[w.polygon_id] = w.vertex_index + 1;
                end
            end
            KIND_POINT: begin
                r.inside_border = point_in_poly(0, w.coord_x, w.coord_y);
                r.in_obstacle   = hits_obstacle(w.coord_x, w.coord_y);
                r.point_valid   = r.inside_border & ~r.in_obstacle;
                expected_q = {expected_q, r};
            end
            KIND_SEGMENT: begin
                r.segment_blocked = segment_hits(w.coord_x, w.coord_y, w.end_x, w.end_y);
                expected_q = {expected_q, r};
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                t_out e;
                e = expected_q.pop_front();
                if (o_out.inside_border !== e.inside_border)
                    report_mismatch($sformatf("inside_border %b exp %b",
                                              o_out.inside_border, e.inside_border));
                if (o_out.in_obstacle !== e.in_obstacle)
                    report_mismatch($sformatf("in_obstacle %b exp %b",
                                              o_out.in_obstacle, e.in_obstacle));
                if (o_out.point_valid !== e.point_valid)
                    report_mismatch($sformatf("point_valid %b exp %b",
                                              o_out.point_valid, e.point_valid));
                if (o_out.segment_blocked !== e.segment_blocked)
                    report_mismatch($sformatf("segment_blocked %b exp %b",
                                              o_out.segment_blocked, e.segment_blocked));
            end
        end
    end

    always @(posedge i_clk) begin
        case ((cycle_count / 3000) % 4)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ((cycle_count % 17) < 9);
        endcase
    end

    task automatic send_word(input t_in w);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (full);
        predict_validity(w);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_obstacle_count(input int unsigned v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 5'(v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        obs_active = v;
    endtask

    function automatic t_in make_word(input logic [1:0] k, input int p, input int vi,
                                      input bit last, input int x, input int y,
                                      input int ex, input int ey);
        t_in w;
        w.kind         = k;
        w.polygon_id   = 5'(p);
        w.vertex_index = 5'(vi);
        w.last_vertex  = last;
        w.coord_x      = 16'(x);
        w.coord_y      = 16'(y);
        w.end_x        = 16'(ex);
        w.end_y        = 16'(ey);
        return w;
    endfunction

    function automatic int rand_coord(input int span);
        if ($urandom_range(0, 9) == 0) return $signed(16'($urandom));
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic load_polygon(input int p, input int n, input int cx, input int cy,
                                input int rad);
        int x;
        int y;
        for (int i = 0; i < n; i++) begin
            x = cx + int'(rad * $cos(6.2831853 * i / n)) + int'($urandom_range(0, rad / 4));
            y = cy + int'(rad * $sin(6.2831853 * i / n)) + int'($urandom_range(0, rad / 4));
            if (x > 32767) x = 32767;
            if (x < -32768) x = -32768;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            send_word(make_word(KIND_LOAD, p, i, i == n - 1, x, y, 0, 0));
        end
    endtask

    task automatic test_directed();
        send_word(make_word(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(KIND_SEGMENT, 0, 0, 0, -32768, -32768, 32767, 32767));
        send_word(make_word(KIND_LOAD, 0, 0, 0, -32768, -32768, 0, 0));
        send_word(make_word(KIND_LOAD, 0, 1, 0, 32767, -32768, 0, 0));
        send_word(make_word(KIND_LOAD, 0, 2, 0, 32767, 32767, 0, 0));
        send_word(make_word(KIND_LOAD, 0, 3, 1, -32768, 32767, 0, 0));
        send_word(make_word(KIND_LOAD, 17, 3, 1, 5, 5, 0, 0));
        send_word(make_word(KIND_LOAD, 31, 31, 1, 5, 5, 0, 0));
        send_word(make_word(KIND_NONE, 31, 31, 1, -1, -1, -1, -1));
        send_word(make_word(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(KIND_POINT, 0, 0, 0, -32768, -32768, 0, 0));
        send_word(make_word(KIND_POINT, 0, 0, 0, 32767, 32767, 0, 0));
        send_word(make_word(KIND_LOAD, 1, 0, 0, -100, -100, 0, 0));
        send_word(make_word(KIND_LOAD, 1, 1, 0, 100, -100, 0, 0));
        send_word(make_word(KIND_LOAD, 1, 2, 1, 0, 100, 0, 0));
        send_word(make_word(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
        write_obstacle_count(1);
        send_word(make_word(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(KIND_POINT, 0, 0, 0, 0, -100, 0, 0));
        send_word(make_word(KIND_SEGMENT, 0, 0, 0, -1000, 0, 1000, 0));
        send_word(make_word(KIND_SEGMENT, 0, 0, 0, 1000, 5000, 999, 5001));
        send_word(make_word(KIND_SEGMENT, 0, 0, 0, -7, -3, -7, -3));
    endtask

    task automatic test_random_queries(input int unsigned n_items);
        int unsigned pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_word(make_word(KIND_POINT, $urandom, $urandom, 1'($urandom),
                                    rand_coord(3000), rand_coord(3000), $urandom, $urandom));
            else if (pick < 75)
                send_word(make_word(KIND_SEGMENT, $urandom, $urandom, 1'($urandom),
                                    rand_coord(3000), rand_coord(3000),
                                    rand_coord(3000), rand_coord(3000)));
            else if (pick < 85)
                send_word(make_word(KIND_NONE, $urandom, $urandom, 1'($urandom),
                                    $urandom, $urandom, $urandom, $urandom));
            else if (pick < 92)
                send_word(make_word(KIND_LOAD, $urandom_range(17, 31), $urandom, 1'($urandom),
                                    $urandom, $urandom, $urandom, $urandom));
            else begin
                int p;
                int vi;
                p = $urandom_range(0, MAX_OBS);
                vi = (poly_len[p] == 0) ? 0 : $urandom_range(0, poly_len[p] - 1);
                send_word(make_word(KIND_LOAD, p, vi, poly_len[p] == 0 || vi == poly_len[p] - 1,
                                    rand_coord(3000), rand_coord(3000), $urandom, $urandom));
            end
        end
    endtask

    task automatic test_map_sweep();
        load_polygon(0, 32, 0, 0, 5000);
        for (int p = 1; p <= MAX_OBS; p++)
            load_polygon(p, $urandom_range(3, 8), rand_coord(4000), rand_coord(4000),
                         $urandom_range(200, 1500));
        write_obstacle_count(16);
        test_random_queries(250);
        write_obstacle_count(31);
        test_random_queries(150);
        write_obstacle_count(0);
        test_random_queries(150);
        write_obstacle_count($urandom_range(2, 8));
        load_polygon(3, MAX_VERT, 0, 0, 2500);
        load_polygon(0, 3, 0, 0, 30000);
        test_random_queries(250);
        write_obstacle_count(5);
        test_random_queries(150);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        pop         = 1'b0;
        error_count = 0;
        cycle_count = 0;
        burst_left  = 0;
        obs_active  = 0;
        for (int p = 0; p < NUM_POLYS; p++) poly_len[p] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_map_sweep();
        wait_idle();
        repeat (3000) @(posedge i_clk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
